// File: hdl/ofd_pkg.sv
// ----------------------------------------------------------------------------
// ofd_pkg
// Shared types, constants and the frame decode function of the OOK
// Manchester frame decoder.
// ----------------------------------------------------------------------------
package ofd_pkg;

  // Frame geometry
  localparam int FRAME_BITS   = 56;
  localparam int NIBBLES      = FRAME_BITS / 4;
  localparam int PAIR_HALVES  = 2 * FRAME_BITS;
  localparam int HALF_STOP    = 116;
  localparam int HALF_DEPTH   = 117;
  localparam int HALF_W       = $clog2(HALF_DEPTH + 1);

  // Token queue between classifier and collector
  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

  // Configuration port
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  // Register reset values
  localparam logic [15:0] SHORT_LEN_RST  = 16'd640;
  localparam logic [15:0] LONG_LEN_RST   = 16'd1280;
  localparam logic [15:0] PULSE_TOL_RST  = 16'd250;
  localparam logic [15:0] SYNC_LEN_RST   = 16'd4550;
  localparam logic [15:0] SYNC_TOL_RST   = 16'd900;
  localparam logic [15:0] MIN_PULSES_RST = 16'd100;

  localparam logic [15:0] PULSE_COUNT_MAX = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHORT_LEN  = 3'd0,
    REG_LONG_LEN   = 3'd1,
    REG_PULSE_TOL  = 3'd2,
    REG_SYNC_LEN   = 3'd3,
    REG_SYNC_TOL   = 3'd4,
    REG_MIN_PULSES = 3'd5
  } ofd_reg_t;

  typedef enum logic [1:0] {
    PH_SEARCH  = 2'd0,
    PH_COLLECT = 2'd1,
    PH_STOPPED = 2'd2
  } ofd_phase_t;

  // One classified pulse
  typedef struct packed {
    logic level;
    logic is_sync;
    logic is_short;
    logic is_long;
    logic last;
  } ofd_token_t;

  typedef struct packed {
    logic                  ok;
    logic [FRAME_BITS-1:0] key;
  } ofd_try_t;

  // Decode one try: offset into the half-symbols and polarity
  function automatic ofd_try_t ofd_try(input logic [HALF_DEPTH-1:0] halves,
                                       input logic off,
                                       input logic inv,
                                       input logic [HALF_W-1:0] hc);
    ofd_try_t              r;
    logic [HALF_DEPTH-1:0] hs;
    logic [FRAME_BITS-1:0] f;
    logic [FRAME_BITS-1:0] d;
    logic [3:0]            ck;
    logic                  pairs_ok;
    logic                  enough;
    hs = off ? (halves >> 1) : halves;
    pairs_ok = 1'b1;
    for (int i = 0; i < FRAME_BITS; i++) begin
      pairs_ok = pairs_ok & (hs[2*i] ^ hs[2*i+1]);
      // low,high is a one at normal polarity
      f[FRAME_BITS-1-i] = inv ? hs[2*i] : hs[2*i+1];
    end
    d = f ^ (f >> 8);
    ck = 4'd0;
    for (int n = 0; n < NIBBLES; n++) begin
      ck = ck ^ d[4*n +: 4];
    end
    enough = {1'b0, hc} >= ((HALF_W+1)'(PAIR_HALVES) + {{HALF_W{1'b0}}, off});
    r.ok  = pairs_ok && (ck == 4'd0) && enough;
    r.key = d;
    return r;
  endfunction

endpackage

// File: hdl/ofd_ifs.sv
// ----------------------------------------------------------------------------
// ofd_ifs
// Channel interfaces: pulse input, configuration write and result output.
// ----------------------------------------------------------------------------
interface ofd_pulse_if;
  logic        valid;
  logic        ready;
  logic        level;
  logic [15:0] duration_us;
  logic        capture_end;
  modport source (output valid, level, duration_us, capture_end, input ready);
  modport sink   (input valid, level, duration_us, capture_end, output ready);
endinterface

interface ofd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ofd_pkg::CFG_IDX_W-1:0]  index;
  logic [ofd_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface ofd_result_if;
  logic        valid;
  logic        ready;
  logic        frame_ok;
  logic [3:0]  command;
  logic [15:0] rolling_code;
  logic [23:0] address;
  logic [55:0] frame_key;
  modport source (output valid, frame_ok, command, rolling_code, address, frame_key,
                  input ready);
  modport sink   (input valid, frame_ok, command, rolling_code, address, frame_key,
                  output ready);
endinterface

// File: hdl/ook_manchester_frame_decoder.sv
// ----------------------------------------------------------------------------
// ook_manchester_frame_decoder
// OOK Manchester 56-bit frame decoder: pulse classifier, token queue and
// half-symbol collector with frame decode.
// ----------------------------------------------------------------------------
// Feed one pulse per transfer; the block takes one pulse every clock cycle
// while the queue has room. The classifier compares each pulse with the sync,
// short and long windows and pushes a token into a four-deep queue; the
// collector takes one token a cycle unless held and builds up to 117
// half-symbols. When nothing stalls, the pulse marked capture_end yields one
// result: the queue registers it, the collector takes it at the head and
// snapshots the capture status, and the parallel decode of all four tries
// loads the result register, where the result waits. While a result waits
// and a further capture end is pending decode, the collector holds and the
// queue absorbs up to four pulses before the input stalls.
module ook_manchester_frame_decoder (
  input  logic         clk,
  input  logic         rst,
  ofd_pulse_if.sink    pulses,
  ofd_cfg_if.sink      cfg,
  ofd_result_if.source results
);
  import ofd_pkg::*;

  ofd_token_t  f_tok;
  logic        f_valid;
  logic        f_ready;
  ofd_token_t  q_tok;
  logic        q_valid;
  logic        q_ready;
  logic [15:0] min_pulses;

  ofd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pulses     (pulses),
    .cfg        (cfg),
    .tok        (f_tok),
    .tok_valid  (f_valid),
    .tok_ready  (f_ready),
    .min_pulses (min_pulses)
  );

  ofd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_tok    (f_tok),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .out_tok   (q_tok),
    .out_valid (q_valid),
    .out_ready (q_ready)
  );

  ofd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .tok        (q_tok),
    .tok_valid  (q_valid),
    .tok_ready  (q_ready),
    .min_pulses (min_pulses),
    .results    (results)
  );

endmodule

// File: hdl/ofd_front.sv
// ----------------------------------------------------------------------------
// ofd_front
// Configuration registers and pulse classifier: each accepted pulse becomes
// a token that says which length window it falls in.
// ----------------------------------------------------------------------------
module ofd_front (
  input  logic               clk,
  input  logic               rst,
  ofd_pulse_if.sink          pulses,
  ofd_cfg_if.sink            cfg,
  output ofd_pkg::ofd_token_t tok,
  output logic               tok_valid,
  input  logic               tok_ready,
  output logic [15:0]        min_pulses
);
  import ofd_pkg::*;

  logic [15:0] short_len;
  logic [15:0] long_len;
  logic [15:0] pulse_tol;
  logic [15:0] sync_len;
  logic [15:0] sync_tol;

  logic [15:0] d_short;
  logic [15:0] d_long;
  logic [15:0] d_sync;
  logic [15:0] dur;

  // Take writes at any time
  assign cfg.ready = 1'b1;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      short_len  <= SHORT_LEN_RST;
      long_len   <= LONG_LEN_RST;
      pulse_tol  <= PULSE_TOL_RST;
      sync_len   <= SYNC_LEN_RST;
      sync_tol   <= SYNC_TOL_RST;
      min_pulses <= MIN_PULSES_RST;
    end else if (cfg.valid) begin
      case (ofd_reg_t'(cfg.index))
        REG_SHORT_LEN:  short_len  <= cfg.data;
        REG_LONG_LEN:   long_len   <= cfg.data;
        REG_PULSE_TOL:  pulse_tol  <= cfg.data;
        REG_SYNC_LEN:   sync_len   <= cfg.data;
        REG_SYNC_TOL:   sync_tol   <= cfg.data;
        REG_MIN_PULSES: min_pulses <= cfg.data;
        default: ;
      endcase
    end
  end

  // Distance of the pulse length to each nominal length
  assign dur     = pulses.duration_us;
  assign d_short = (dur > short_len) ? dur - short_len : short_len - dur;
  assign d_long  = (dur > long_len)  ? dur - long_len  : long_len - dur;
  assign d_sync  = (dur > sync_len)  ? dur - sync_len  : sync_len - dur;

  // Classify into a token; the queue registers it
  always_comb begin
    tok.level    = pulses.level;
    tok.is_sync  = pulses.level && (d_sync < sync_tol);
    tok.is_short = d_short < pulse_tol;
    tok.is_long  = d_long < pulse_tol;
    tok.last     = pulses.capture_end;
  end

  assign tok_valid    = pulses.valid;
  assign pulses.ready = tok_ready;

endmodule

// File: hdl/ofd_queue.sv
// ----------------------------------------------------------------------------
// ofd_queue
// Short token queue between classifier and collector, so that each side
// stalls on its own.
// ----------------------------------------------------------------------------
module ofd_queue (
  input  logic                clk,
  input  logic                rst,
  input  ofd_pkg::ofd_token_t in_tok,
  input  logic                in_valid,
  output logic                in_ready,
  output ofd_pkg::ofd_token_t out_tok,
  output logic                out_valid,
  input  logic                out_ready
);
  import ofd_pkg::*;

  ofd_token_t            slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   head;
  logic [QUEUE_AW-1:0]   tail;
  logic [QUEUE_AW:0]     count;
  logic                  push;
  logic                  pop;

  assign in_ready  = count != (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_tok   = slots[head];

  // Store on transfer in
  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= in_tok;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) tail <= tail + 1'b1;
      if (pop)  head <= head + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hdl/ofd_back.sv
// ----------------------------------------------------------------------------
// ofd_back
// Half-symbol collector, frame decode stage and result register.
// ----------------------------------------------------------------------------
module ofd_back (
  input  logic                clk,
  input  logic                rst,
  input  ofd_pkg::ofd_token_t tok,
  input  logic                tok_valid,
  output logic                tok_ready,
  input  logic [15:0]         min_pulses,
  ofd_result_if.source        results
);
  import ofd_pkg::*;

  ofd_phase_t            phase;
  ofd_phase_t            phase_step;
  ofd_phase_t            phase_next;
  logic [HALF_W-1:0]     hc;
  logic [HALF_W-1:0]     hc_step;
  logic [HALF_W-1:0]     hc_plus1;
  logic [15:0]           pc;
  logic [15:0]           pc_step;
  logic [HALF_DEPTH-1:0] halves;
  logic                  wr0;
  logic                  wr1;
  logic                  pop;

  logic                  dec_pending;
  logic                  dec_pre;
  logic [HALF_W-1:0]     dec_hc;
  ofd_try_t              t_n0;
  ofd_try_t              t_n1;
  ofd_try_t              t_i0;
  ofd_try_t              t_i1;
  logic                  res_ok;
  logic [FRAME_BITS-1:0] res_key;

  logic                  out_valid;
  logic                  out_ok;
  logic [FRAME_BITS-1:0] out_key;
  logic                  out_load;

  // Take a token unless a decode waits on a full result register
  assign out_load  = !out_valid || results.ready;
  assign tok_ready = !dec_pending || out_load;
  assign pop       = tok_valid && tok_ready;
  assign hc_plus1  = hc + 1'b1;
  assign pc_step   = (pc == PULSE_COUNT_MAX) ? pc : pc + 1'b1;

  // Next phase
  always_comb begin
    phase_step = phase;
    if (pop) begin
      case (phase)
        PH_SEARCH: begin
          if (tok.is_sync) phase_step = PH_COLLECT;
        end
        PH_COLLECT: begin
          if (!tok.is_short && !tok.is_long) begin
            phase_step = PH_STOPPED;
          end else if (hc_step >= HALF_W'(HALF_STOP)) begin
            phase_step = PH_STOPPED;
          end
        end
        PH_STOPPED: phase_step = PH_STOPPED;
        default:    phase_step = PH_SEARCH;
      endcase
    end
    phase_next = (pop && tok.last) ? PH_SEARCH : phase_step;
  end

  // Half-symbol writes and count
  always_comb begin
    wr0     = 1'b0;
    wr1     = 1'b0;
    hc_step = hc;
    if (pop) begin
      case (phase)
        PH_SEARCH: begin
          if (tok.is_sync) hc_step = '0;
        end
        PH_COLLECT: begin
          if (tok.is_short) begin
            wr0     = hc < HALF_W'(HALF_DEPTH);
            hc_step = hc + HALF_W'(wr0);
          end else if (tok.is_long) begin
            wr0     = hc < HALF_W'(HALF_DEPTH);
            wr1     = hc_plus1 < HALF_W'(HALF_DEPTH);
            hc_step = hc + HALF_W'(wr0) + HALF_W'(wr1);
          end
        end
        default: ;
      endcase
    end
  end

  // Collector state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SEARCH;
      hc    <= '0;
      pc    <= '0;
    end else begin
      phase <= phase_next;
      if (pop) begin
        hc <= tok.last ? '0 : hc_step;
        pc <= tok.last ? '0 : pc_step;
      end
    end
  end

  // Half-symbol store
  always_ff @(posedge clk) begin
    for (int j = 0; j < HALF_DEPTH; j++) begin
      if ((wr0 && hc == HALF_W'(j)) || (wr1 && hc_plus1 == HALF_W'(j))) begin
        halves[j] <= tok.level;
      end
    end
  end

  // Snapshot capture status on the last pulse
  always_ff @(posedge clk) begin
    if (pop && tok.last) begin
      dec_pre <= (pc_step >= min_pulses) && (phase_step != PH_SEARCH) &&
                 (hc_step >= HALF_W'(PAIR_HALVES));
      dec_hc  <= hc_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_pending <= 1'b0;
    end else if (pop && tok.last) begin
      dec_pending <= 1'b1;
    end else if (out_load) begin
      dec_pending <= 1'b0;
    end
  end

  // Four tries in priority order
  always_comb begin
    t_n0 = ofd_try(halves, 1'b0, 1'b0, dec_hc);
    t_n1 = ofd_try(halves, 1'b1, 1'b0, dec_hc);
    t_i0 = ofd_try(halves, 1'b0, 1'b1, dec_hc);
    t_i1 = ofd_try(halves, 1'b1, 1'b1, dec_hc);
    res_ok  = dec_pre && (t_n0.ok || t_n1.ok || t_i0.ok || t_i1.ok);
    res_key = '0;
    if (dec_pre) begin
      if (t_n0.ok)      res_key = t_n0.key;
      else if (t_n1.ok) res_key = t_n1.key;
      else if (t_i0.ok) res_key = t_i0.key;
      else if (t_i1.ok) res_key = t_i1.key;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= dec_pending;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && dec_pending) begin
      out_ok  <= res_ok;
      out_key <= res_key;
    end
  end

  assign results.valid        = out_valid;
  assign results.frame_ok     = out_ok;
  assign results.command      = out_key[47:44];
  assign results.rolling_code = out_key[39:24];
  assign results.address      = out_key[23:0];
  assign results.frame_key    = out_key;

`ifndef NO_ASSERTIONS
  a_hc_bound: assert property (@(posedge clk) disable iff (rst)
    hc <= HALF_W'(HALF_DEPTH))
    else $error("half count beyond store depth");

  a_hold_decode: assert property (@(posedge clk) disable iff (rst)
    dec_pending && !out_load |=> dec_pending && $stable(halves))
    else $error("pending decode lost its half-symbols");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ok |-> out_key == '0)
    else $error("failed frame carries a key");

  a_end_reset: assert property (@(posedge clk) disable iff (rst)
    pop && tok.last |=> phase == PH_SEARCH && hc == '0 && pc == '0)
    else $error("collector not cleared after capture end");
`endif

endmodule
